@@ rtl/euler_xyz_to_rotation_matrix_core_defines.svh @@
// Assertion macros shared by the rotation matrix RTL.
`ifndef EULER_XYZ_TO_ROTATION_MATRIX_CORE_DEFINES_SVH
`define EULER_XYZ_TO_ROTATION_MATRIX_CORE_DEFINES_SVH

// Assert that a property holds on every clock edge out of reset.
`define EXR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition implies a consequence in the following cycle.
`define EXR_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/exr_pkg.sv @@
// Package: constants, types and helpers for the rotation matrix core.
`timescale 1ns / 1ps
package exr_pkg;
    localparam int ANGLE_BITS    = 24;
    localparam int OUT_FRAC_BITS = 16;
    localparam int CORDIC_STEPS  = 18;
    localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
    localparam int WORK_FRAC     = 30;
    localparam int WORK_W        = 34;
    localparam int RAD_SHIFT     = ANGLE_BITS - 4 + 2;
    localparam int DEG_SHIFT     = ANGLE_BITS - 12 + 8;
    localparam logic [31:0] RAD_TO_PHASE = 32'd2734261102;
    localparam logic [31:0] DEG_TO_PHASE = 32'd3054198966;
    localparam logic signed [WORK_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [OUT_WIDTH-1:0] ent_t;

    typedef struct packed {
        logic [31:0] roll;
        logic [31:0] pitch;
        logic [31:0] yaw;
    } phase_word_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t [32];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    // Q4.30 product rounded half up.
    function automatic work_t mulq(input work_t a, input work_t b);
        logic signed [2*WORK_W-1:0] p;
        p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
        return work_t'(p >>> WORK_FRAC);
    endfunction

    // Round to output precision and clamp to +-1.
    function automatic ent_t finish(input work_t v);
        work_t r;
        work_t lim;
        r = (v + (work_t'(1) <<< (WORK_FRAC - OUT_FRAC_BITS - 1))) >>>
            (WORK_FRAC - OUT_FRAC_BITS);
        lim = work_t'(1) <<< OUT_FRAC_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return ent_t'(r);
    endfunction
endpackage

@@ rtl/exr_front.sv @@
// Front end: converts the three angles to 32-bit phases.
`timescale 1ns / 1ps
module exr_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    angle_unit,
    input  exr_pkg::angle_t         roll_angle,
    input  exr_pkg::angle_t         pitch_angle,
    input  exr_pkg::angle_t         yaw_angle,
    input  logic                    in_fire,
    output logic                    ph_valid,
    output exr_pkg::phase_word_t    ph_word
);
    import exr_pkg::*;

    logic        v_reg;
    phase_word_t w_reg;

    function automatic logic [31:0] to_phase(input angle_t a, input logic deg);
        logic signed [63:0] p;
        p = 64'(signed'(a)) * $signed({32'd0, deg ? DEG_TO_PHASE : RAD_TO_PHASE});
        if (deg)
            return 32'((p + (64'sd1 <<< (DEG_SHIFT - 1))) >>> DEG_SHIFT);
        return 32'((p + (64'sd1 <<< (RAD_SHIFT - 1))) >>> RAD_SHIFT);
    endfunction

    // Register phases for each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            w_reg.roll  <= to_phase(roll_angle, angle_unit);
            w_reg.pitch <= to_phase(pitch_angle, angle_unit);
            w_reg.yaw   <= to_phase(yaw_angle, angle_unit);
        end
    end

    assign ph_valid = v_reg;
    assign ph_word  = w_reg;
endmodule

@@ rtl/exr_back.sv @@
// Back end: pipelined CORDIC, products and output register.
`timescale 1ns / 1ps
module exr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  exr_pkg::phase_word_t in_word,
    output logic                 out_valid,
    output exr_pkg::ent_t        o_m [9]
);
    import exr_pkg::*;

    localparam int NS = CORDIC_STEPS;
    localparam int NL = NS + 5;

    logic        v_reg [NL];
    work_t       x_reg [NS+1][3];
    work_t       y_reg [NS+1][3];
    logic signed [32:0] z_reg [NS+1][3];
    logic [1:0]  q_reg [NS+1][3];
    work_t       c_reg [3], s_reg [3];
    work_t       spsr_reg, spcr_reg, cr_reg, sr_reg, cp_reg, sp_reg, cy_reg, sy_reg;
    work_t       spd_reg;
    work_t       pa_reg [8];
    ent_t        m_reg [9];
    logic [31:0] ph [3];
    logic [1:0]  qn [3];
    logic [31:0] ru [3];

    assign ph[0] = in_word.roll;
    assign ph[1] = in_word.pitch;
    assign ph[2] = in_word.yaw;

    // Quadrant split of each phase.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qn[k] = 2'((ph[k] + 32'h20000000) >> 30);
            ru[k] = ph[k] - {qn[k], 30'd0};
        end
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++) v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NL; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // CORDIC stages, one micro-rotation per stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x_reg[0][k] <= CORDIC_GAIN;
                y_reg[0][k] <= '0;
                z_reg[0][k] <= 33'(signed'(ru[k]));
                q_reg[0][k] <= qn[k];
                for (int i = 0; i < NS; i++)
                begin
                    q_reg[i+1][k] <= q_reg[i][k];
                    if (!z_reg[i][k][32])
                    begin
                        x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] - $signed({1'b0, atan_turn(i)});
                    end
                    else
                    begin
                        x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] + $signed({1'b0, atan_turn(i)});
                    end
                end
                // Quadrant fix-up.
                case (q_reg[NS][k])
                    2'd0:
                    begin
                        c_reg[k] <= x_reg[NS][k];  s_reg[k] <= y_reg[NS][k];
                    end
                    2'd1:
                    begin
                        c_reg[k] <= -y_reg[NS][k]; s_reg[k] <= x_reg[NS][k];
                    end
                    2'd2:
                    begin
                        c_reg[k] <= -x_reg[NS][k]; s_reg[k] <= -y_reg[NS][k];
                    end
                    default:
                    begin
                        c_reg[k] <= y_reg[NS][k];  s_reg[k] <= -x_reg[NS][k];
                    end
                endcase
            end
            // First products.
            spsr_reg <= mulq(s_reg[1], s_reg[0]);
            spcr_reg <= mulq(s_reg[1], c_reg[0]);
            cr_reg <= c_reg[0]; sr_reg <= s_reg[0];
            cp_reg <= c_reg[1]; sp_reg <= s_reg[1];
            cy_reg <= c_reg[2]; sy_reg <= s_reg[2];
            // Second products.
            pa_reg[0] <= mulq(cy_reg, cp_reg);
            pa_reg[1] <= mulq(cy_reg, spsr_reg) - mulq(sy_reg, cr_reg);
            pa_reg[2] <= mulq(cy_reg, spcr_reg) + mulq(sy_reg, sr_reg);
            pa_reg[3] <= mulq(sy_reg, cp_reg);
            pa_reg[4] <= mulq(sy_reg, spsr_reg) + mulq(cy_reg, cr_reg);
            pa_reg[5] <= mulq(sy_reg, spcr_reg) - mulq(cy_reg, sr_reg);
            pa_reg[6] <= mulq(cp_reg, sr_reg);
            pa_reg[7] <= mulq(cp_reg, cr_reg);
            spd_reg   <= sp_reg;
            // Round and clamp.
            m_reg[0] <= finish(pa_reg[0]);
            m_reg[1] <= finish(pa_reg[1]);
            m_reg[2] <= finish(pa_reg[2]);
            m_reg[3] <= finish(pa_reg[3]);
            m_reg[4] <= finish(pa_reg[4]);
            m_reg[5] <= finish(pa_reg[5]);
            m_reg[6] <= finish(-spd_reg);
            m_reg[7] <= finish(pa_reg[6]);
            m_reg[8] <= finish(pa_reg[7]);
        end
    end

    assign out_valid = v_reg[NL-1];
    assign o_m = m_reg;
endmodule

@@ rtl/euler_xyz_to_rotation_matrix_core.sv @@
// Throughput: one word per cycle unless stalled; front phase stage feeds a 4-deep
// queue and the back pipeline (18 CORDIC stages, two product stages, rounding)
// advances whenever its result register is free or being taken. Reset clears all
// valid bits, the queue and angle_unit (radians).
`timescale 1ns / 1ps
`include "euler_xyz_to_rotation_matrix_core_defines.svh"
module euler_xyz_to_rotation_matrix_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  exr_pkg::angle_t roll_angle,
    input  exr_pkg::angle_t pitch_angle,
    input  exr_pkg::angle_t yaw_angle,
    output logic            out_valid,
    input  logic            out_stall,
    output exr_pkg::ent_t   m00, m01, m02, m10, m11, m12, m20, m21, m22
);
    import exr_pkg::*;

    logic        unit_reg;
    logic        in_fire, ph_valid, adv, bk_valid;
    phase_word_t ph_word;
    phase_word_t q_mem [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic        q_pop;
    ent_t        m [9];

    assign cfg_ready = 1'b1;

    // Hold the unit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) unit_reg <= 1'b0;
        else if (cfg_valid && cfg_ready) unit_reg <= cfg_data;
    end

    // Stall while the queue and the word in the phase stage leave no room.
    assign in_stall = (32'(cnt_reg) + 32'(ph_valid) >= QDEPTH);
    assign in_fire  = in_valid && !in_stall;

    exr_front u_front (
        .clk, .rst_n, .angle_unit(unit_reg),
        .roll_angle, .pitch_angle, .yaw_angle,
        .in_fire, .ph_valid, .ph_word
    );

    // Back pipe advances while its output is free or taken.
    assign adv   = !bk_valid || !out_stall;
    assign q_pop = adv && (cnt_reg != '0);

    always_comb
    begin
        cnt_next = cnt_reg + (QPTR_W+1)'(ph_valid) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (ph_valid) wp_reg <= wp_reg + 1'b1;
            if (q_pop)    rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (ph_valid) q_mem[wp_reg] <= ph_word;
    end

    exr_back u_back (
        .clk, .rst_n, .adv, .in_valid(q_pop), .in_word(q_mem[rp_reg]),
        .out_valid(bk_valid), .o_m(m)
    );

    assign out_valid = bk_valid;
    assign m00 = m[0]; assign m01 = m[1]; assign m02 = m[2];
    assign m10 = m[3]; assign m11 = m[4]; assign m12 = m[5];
    assign m20 = m[6]; assign m21 = m[7]; assign m22 = m[8];

    `EXR_ASSERT(a_q_no_over, (32'(cnt_reg) <= QDEPTH), "queue overflow")
    `EXR_ASSERT(a_q_push_room, !(ph_valid && (32'(cnt_reg) == QDEPTH)), "push into full queue")
    `EXR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(m00),
        "result dropped under stall")
endmodule
